// ===== rtl/core/jpeg_marker_dht_parser_unit_defines.svh =====
// assertion helpers for the parser top-level rtl
`ifndef JPEG_MARKER_DHT_PARSER_UNIT_DEFINES_SVH
`define JPEG_MARKER_DHT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, held off while in reset
`define JMDP_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("jmdp same-cycle check failed");

// next-cycle implication, held off while in reset
`define JMDP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("jmdp next-cycle check failed");

`endif

// ===== rtl/core/jmdp_pkg.sv =====
`default_nettype none
package jmdp_pkg;

  localparam int MAX_CODE_LENGTH = 16;
  localparam int LEN_IDX_W = $clog2(MAX_CODE_LENGTH);
  localparam int LEN_SRCH_W = LEN_IDX_W + 1;

  localparam logic [15:0] MARKER_BASE = 16'hFFC0;
  localparam logic [15:0] MARKER_DHT = 16'hFFC4;
  localparam logic [15:0] MARKER_EOI = 16'hFFD9;
  localparam logic [15:0] MARKER_SOI = 16'hFFD8;
  localparam logic [15:0] MARKER_SOS = 16'hFFDA;
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] EOI_LOW = MARKER_EOI[7:0];

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [3:0] {
    PH_MARK_HI,
    PH_MARK_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_DHT_LEN_HI,
    PH_DHT_LEN_LO,
    PH_DHT_TABLE,
    PH_DHT_COUNTS,
    PH_DHT_SYMS,
    PH_SCAN,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    EV_SEGMENT,
    EV_HUFF,
    EV_EOI,
    EV_NO_MARKER,
    EV_DHT_MISMATCH
  } event_t;

  typedef struct packed {
    event_t      kind;
    logic [5:0]  marker_index;
    logic [31:0] segment_offset;
    logic [7:0]  table_number;
    logic [4:0]  code_length;
    logic [15:0] code_bits;
    logic [7:0]  symbol_value;
    logic        last;
  } res_t;

  // results made by one byte, first goes out first
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } step_t;

  typedef struct packed {
    logic halted;
  } core_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/jpeg_marker_dht_parser_unit.sv =====
// path: input register, then a four-word queue, drained one per cycle on out_ready
// throughput: one byte per cycle while the queue has room; the end-of-image byte
//   and the last symbol of a bad huffman table give two words
// reset: synchronous rst clears the parse state, position counter, byte-held flag and
//   queue; the code-length count table keeps its contents and is rewritten per table
`default_nettype none
`include "jpeg_marker_dht_parser_unit_defines.svh"
module jpeg_marker_dht_parser_unit import jmdp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_kind,
  output logic [5:0]       marker_index,
  output logic [31:0]      segment_offset,
  output logic [7:0]       table_number,
  output logic [4:0]       code_length,
  output logic [15:0]      code_bits,
  output logic [7:0]       symbol_value,
  output logic             last_of_run
);

  logic         byte_held;
  logic [7:0]   byte_reg;
  logic         adv;
  logic         fifo_space;
  step_t        step;
  core_status_t status;
  res_t         head;

  assign adv      = byte_held && fifo_space;
  assign in_ready = !byte_held || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_held <= 1'b1;
    end else if (adv) begin
      byte_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_reg <= data_byte;
  end

  jmdp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .data   (byte_reg),
    .step   (step),
    .status (status)
  );

  jmdp_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .pop        (out_valid && out_ready),
    .head       (head),
    .head_valid (out_valid),
    .space      (fifo_space)
  );

  assign event_kind     = head.kind;
  assign marker_index   = head.marker_index;
  assign segment_offset = head.segment_offset;
  assign table_number   = head.table_number;
  assign code_length    = head.code_length;
  assign code_bits      = head.code_bits;
  assign symbol_value   = head.symbol_value;
  assign last_of_run    = head.last;

  `JMDP_ASSERT_NOW(a_no_push_when_full, clk, rst, !fifo_space, step.count == 2'd0)
  `JMDP_ASSERT_NEXT(a_pair_then_halt, clk, rst, step.count == 2'd2, status.halted)
  `JMDP_ASSERT_NEXT(a_halt_sticks, clk, rst, status.halted, status.halted)

endmodule
`default_nettype wire

// ===== rtl/core/jmdp_core.sv =====
`default_nettype none
module jmdp_core import jmdp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  input  wire logic [7:0]   data,
  output step_t             step,
  output core_status_t      status
);

  phase_t                 parse_phase, parse_phase_next;
  logic [31:0]            byte_position, byte_position_next;
  logic [31:0]            marker_start, marker_start_next;
  logic [7:0]             word_high_byte, word_high_byte_next;
  logic [15:0]            declared_length, declared_length_next;
  logic [15:0]            skip_remaining, skip_remaining_next;
  logic [7:0]             current_table, current_table_next;
  logic [7:0]             length_counts [MAX_CODE_LENGTH];
  logic [MAX_CODE_LENGTH-1:0] count_nonzero, count_nonzero_next;
  logic [LEN_IDX_W-1:0]   length_index, length_index_next;
  logic [7:0]             symbols_left, symbols_left_next;
  logic [15:0]            next_code, next_code_next;
  logic [15:0]            dht_consumed, dht_consumed_next;
  logic                   saw_ff, saw_ff_next;

  logic                   counts_we;
  logic                   do_marker;
  logic [15:0]            marker_id;
  logic                   do_finish;
  logic [LEN_SRCH_W-1:0]  found;
  logic [LEN_SRCH_W-1:0]  shift;
  logic [MAX_CODE_LENGTH-1:0] mask_full;
  logic [7:0]             found_count;
  logic [15:0]            code_inc;
  logic [15:0]            skip_len;
  res_t                   rec;

  // lowest set bit at or above start, MAX_CODE_LENGTH when none
  function automatic logic [LEN_SRCH_W-1:0] first_from(
    input logic [MAX_CODE_LENGTH-1:0] mask,
    input logic [LEN_SRCH_W-1:0] start
  );
    logic [LEN_SRCH_W-1:0] r;
    r = LEN_SRCH_W'(MAX_CODE_LENGTH);
    for (int i = MAX_CODE_LENGTH - 1; i >= 0; i--) begin
      if (mask[i] && (LEN_SRCH_W'(i) >= start)) r = LEN_SRCH_W'(i);
    end
    return r;
  endfunction

  function automatic step_t push_res(input step_t s, input res_t r);
    step_t t;
    t = s;
    if (s.count == 2'd0) t.first = r;
    else t.second = r;
    t.count = s.count + 2'd1;
    return t;
  endfunction

  assign status.halted = (parse_phase == PH_HALT);

  always_comb begin
    parse_phase_next     = parse_phase;
    byte_position_next   = byte_position;
    marker_start_next    = marker_start;
    word_high_byte_next  = word_high_byte;
    declared_length_next = declared_length;
    skip_remaining_next  = skip_remaining;
    current_table_next   = current_table;
    count_nonzero_next   = count_nonzero;
    length_index_next    = length_index;
    symbols_left_next    = symbols_left;
    next_code_next       = next_code;
    dht_consumed_next    = dht_consumed;
    saw_ff_next          = saw_ff;
    counts_we            = 1'b0;
    do_marker            = 1'b0;
    marker_id            = {word_high_byte, data};
    do_finish            = 1'b0;
    found                = '0;
    shift                = '0;
    found_count          = '0;
    mask_full            = count_nonzero;
    code_inc             = next_code + 16'd1;
    skip_len             = (declared_length[15:8] != 8'd0 || data >= 8'd2)
                           ? {declared_length[15:8], data} - 16'd2 : 16'd0;
    rec                  = '0;
    step                 = '0;

    if (adv) begin
      byte_position_next = byte_position + 32'd1;
      case (parse_phase)
        PH_MARK_HI: begin
          marker_start_next   = byte_position;
          word_high_byte_next = data;
          parse_phase_next    = PH_MARK_LO;
        end
        PH_MARK_LO: begin
          do_marker = 1'b1;
        end
        PH_LEN_HI: begin
          declared_length_next = {data, 8'h00};
          parse_phase_next     = PH_LEN_LO;
        end
        PH_DHT_LEN_HI: begin
          declared_length_next = {data, 8'h00};
          parse_phase_next     = PH_DHT_LEN_LO;
        end
        PH_LEN_LO: begin
          declared_length_next = {declared_length[15:8], data};
          skip_remaining_next  = skip_len;
          parse_phase_next     = (skip_len == 16'd0) ? PH_MARK_HI : PH_SKIP;
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining - 16'd1;
          if (skip_remaining == 16'd1) parse_phase_next = PH_MARK_HI;
        end
        PH_DHT_LEN_LO: begin
          declared_length_next = {declared_length[15:8], data};
          parse_phase_next     = PH_DHT_TABLE;
        end
        PH_DHT_TABLE: begin
          current_table_next = data;
          dht_consumed_next  = 16'd1;
          length_index_next  = '0;
          parse_phase_next   = PH_DHT_COUNTS;
        end
        PH_DHT_COUNTS: begin
          counts_we                        = 1'b1;
          count_nonzero_next[length_index] = (data != 8'd0);
          mask_full                        = count_nonzero_next;
          dht_consumed_next                = dht_consumed + 16'd1;
          length_index_next                = length_index + LEN_IDX_W'(1);
          if (length_index == LEN_IDX_W'(MAX_CODE_LENGTH - 1)) begin
            // table complete: land on the first nonzero length
            next_code_next = 16'd0;
            found          = first_from(mask_full, '0);
            if (found == LEN_SRCH_W'(MAX_CODE_LENGTH)) begin
              do_finish = 1'b1;
            end else begin
              found_count = (found[LEN_IDX_W-1:0] == length_index)
                            ? data : length_counts[found[LEN_IDX_W-1:0]];
              length_index_next = found[LEN_IDX_W-1:0];
              symbols_left_next = found_count;
              parse_phase_next  = PH_DHT_SYMS;
            end
          end
        end
        PH_DHT_SYMS: begin
          rec.kind         = EV_HUFF;
          rec.table_number = current_table;
          rec.code_length  = {1'b0, length_index} + 5'd1;
          rec.code_bits    = next_code;
          rec.symbol_value = data;
          step             = push_res(step, rec);
          dht_consumed_next = dht_consumed + 16'd1;
          if (symbols_left != 8'd1) begin
            symbols_left_next = symbols_left - 8'd1;
            next_code_next    = code_inc;
          end else begin
            // skip empty lengths, one left shift per length passed
            found = first_from(count_nonzero, {1'b0, length_index} + LEN_SRCH_W'(1));
            shift = found - {1'b0, length_index};
            next_code_next = code_inc << shift;
            symbols_left_next = 8'd0;
            if (found == LEN_SRCH_W'(MAX_CODE_LENGTH)) begin
              do_finish = 1'b1;
            end else begin
              found_count       = length_counts[found[LEN_IDX_W-1:0]];
              length_index_next = found[LEN_IDX_W-1:0];
              symbols_left_next = found_count;
            end
          end
        end
        PH_SCAN: begin
          if (saw_ff && data == EOI_LOW) begin
            saw_ff_next = 1'b0;
            do_marker   = 1'b1;
            marker_id   = MARKER_EOI;
          end else if (data == BYTE_FF) begin
            saw_ff_next       = 1'b1;
            marker_start_next = byte_position;
          end else begin
            saw_ff_next = 1'b0;
          end
        end
        PH_HALT: begin
        end
        default: begin
          parse_phase_next = PH_HALT;
        end
      endcase

      if (do_finish) begin
        if (dht_consumed_next != declared_length - 16'd2) begin
          rec                = '0;
          rec.kind           = EV_DHT_MISMATCH;
          rec.segment_offset = marker_start;
          step               = push_res(step, rec);
          parse_phase_next   = PH_HALT;
        end else begin
          parse_phase_next = PH_MARK_HI;
        end
      end

      if (do_marker) begin
        rec                = '0;
        rec.segment_offset = marker_start;
        if (marker_id < MARKER_BASE) begin
          rec.kind         = EV_NO_MARKER;
          step             = push_res(step, rec);
          parse_phase_next = PH_HALT;
        end else begin
          rec.kind         = EV_SEGMENT;
          rec.marker_index = 6'(marker_id - MARKER_BASE);
          step             = push_res(step, rec);
          if (marker_id == MARKER_DHT) begin
            parse_phase_next = PH_DHT_LEN_HI;
          end else if (marker_id == MARKER_EOI) begin
            rec.kind         = EV_EOI;
            rec.marker_index = '0;
            step             = push_res(step, rec);
            parse_phase_next = PH_HALT;
          end else if (marker_id == MARKER_SOI) begin
            parse_phase_next = PH_MARK_HI;
          end else if (marker_id == MARKER_SOS) begin
            saw_ff_next      = 1'b0;
            parse_phase_next = PH_SCAN;
          end else begin
            parse_phase_next = PH_LEN_HI;
          end
        end
      end

      if (step.count == 2'd1) step.first.last = 1'b1;
      if (step.count == 2'd2) step.second.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_MARK_HI;
      byte_position   <= '0;
      marker_start    <= '0;
      word_high_byte  <= '0;
      declared_length <= '0;
      skip_remaining  <= '0;
      current_table   <= '0;
      count_nonzero   <= '0;
      length_index    <= '0;
      symbols_left    <= '0;
      next_code       <= '0;
      dht_consumed    <= '0;
      saw_ff          <= 1'b0;
    end else begin
      parse_phase     <= parse_phase_next;
      byte_position   <= byte_position_next;
      marker_start    <= marker_start_next;
      word_high_byte  <= word_high_byte_next;
      declared_length <= declared_length_next;
      skip_remaining  <= skip_remaining_next;
      current_table   <= current_table_next;
      count_nonzero   <= count_nonzero_next;
      length_index    <= length_index_next;
      symbols_left    <= symbols_left_next;
      next_code       <= next_code_next;
      dht_consumed    <= dht_consumed_next;
      saw_ff          <= saw_ff_next;
    end
  end

  // count table holds no reset, every entry is written before it is read
  always_ff @(posedge clk) begin
    if (counts_we) length_counts[length_index] <= data;
  end

endmodule
`default_nettype wire

// ===== rtl/core/jmdp_res_fifo.sv =====
`default_nettype none
module jmdp_res_fifo import jmdp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire step_t  push,
  input  wire logic   pop,
  output res_t        head,
  output logic        head_valid,
  output logic        space
);

  res_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  assign head       = entries[rd_ptr];
  assign head_valid = (fill != '0);
  // room for a whole byte's worth of words
  assign space      = (fill <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      fill   <= fill + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
  end

endmodule
`default_nettype wire
